// ===== hw/rtl/utf8dc_pkg.sv =====
package utf8dc_pkg;

   // Fixed field widths
   localparam int CP_W         = 21;
   localparam int POS_W        = 32;
   localparam int LEN_W        = 3;
   localparam int POS_BITS_DEF = 32;

   // Decode limits
   localparam logic [CP_W-1:0] MIN_CP_2B     = 21'h00080;
   localparam logic [CP_W-1:0] MIN_CP_3B     = 21'h00800;
   localparam logic [CP_W-1:0] MIN_CP_4B     = 21'h10000;
   localparam logic [CP_W-1:0] SURR_LO       = 21'h0D800;
   localparam logic [CP_W-1:0] SURR_HI       = 21'h0DFFF;
   localparam logic [CP_W-1:0] MAX_CP        = 21'h10FFFF;

   // Sequence lengths
   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_1B   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2B   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3B   = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4B   = 3'd4;

   // Remaining tail bytes expected
   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_ONE  = 2'd1;
   localparam logic [1:0] TAIL_TWO  = 2'd2;
   localparam logic [1:0] TAIL_THREE = 2'd3;

   typedef enum logic [3:0] {
      KIND_VALID     = 4'd0,
      KIND_OVERLONG  = 4'd1,
      KIND_SURROGATE = 4'd2,
      KIND_RANGE     = 4'd3,
      KIND_LONE_CONT = 4'd4,
      KIND_BAD_START = 4'd5,
      KIND_BAD_CONT  = 4'd6,
      KIND_TRUNC     = 4'd7,
      KIND_END       = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [CP_W-1:0]   cp;
      logic [POS_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
      logic              ok;
   } event_type;

   // Classify a completed multi-byte sequence
   function automatic kind_type classify(input logic [CP_W-1:0] v,
                                         input logic [LEN_W-1:0] len);
      logic [CP_W-1:0] least;
      kind_type        k;
      least = (len == LEN_2B) ? MIN_CP_2B : ((len == LEN_3B) ? MIN_CP_3B : MIN_CP_4B);
      if (v < least) begin
         k = KIND_OVERLONG;
      end else if (v >= SURR_LO && v <= SURR_HI) begin
         k = KIND_SURROGATE;
      end else if (v > MAX_CP) begin
         k = KIND_RANGE;
      end else begin
         k = KIND_VALID;
      end
      return k;
   endfunction

endpackage

// ===== hw/rtl/utf8_stream_decode_check_unit.sv =====
// UTF-8 stream decoder and checker.
// Request channel (req_valid/req_ready): one byte of the stream per request,
// with req_end_of_stream high on the final byte of a stream.
// Result channel (rsp_valid/rsp_ready): zero to three events per byte, in
// order; rsp_run_last marks the last event caused by a byte. Events report
// decoded code points with their class, stray and bad bytes, a truncated
// tail and, for the final byte, an end event carrying the sticky stream_ok.
// Latency: events of a byte appear the cycle after it is accepted.
// Throughput: one byte per cycle while each byte causes at most one event and
// the receiver is ready; a byte causing more events occupies the result register
// while the result side drains one event per cycle from a three-entry event buffer.
// A new byte is taken while the last buffered event is being taken.
// When the receiver stalls, events hold and req_ready stays low until the
// last event of the previous byte is being taken.
// Reset (synchronous) empties the buffer and returns the decoder to the
// start of a stream; the final byte of a stream does the same for decode state.
// Byte positions count per stream and saturate.
module utf8_stream_decode_check_unit #(
   parameter int POS_BITS = utf8dc_pkg::POS_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_byte_value,
   input  logic                           req_end_of_stream,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [3:0]                     rsp_event_kind,
   output logic [utf8dc_pkg::CP_W-1:0]    rsp_code_point,
   output logic [utf8dc_pkg::POS_W-1:0]   rsp_seq_position,
   output logic [utf8dc_pkg::LEN_W-1:0]   rsp_seq_bytes,
   output logic                           rsp_stream_ok,
   output logic                           rsp_run_last
);
   import utf8dc_pkg::*;

   // Decoder state
   logic [1:0]          phase_ff, phase_in;
   logic [CP_W-1:0]     accum_ff, accum_in;
   logic [POS_W-1:0]    seq_begin_ff, seq_begin_in;
   logic [LEN_W-1:0]    seq_len_ff, seq_len_in;
   logic [POS_BITS-1:0] byte_index_ff, byte_index_in;
   logic                all_valid_ff, all_valid_in;

   // Event buffer
   event_type           ev_ff [3];
   event_type           ev_in [3];
   logic [1:0]          cnt_ff, cnt_in;
   logic [1:0]          rd_ff, rd_in;

   logic                req_fire;
   logic                rsp_fire;
   logic [POS_W-1:0]    cur;
   event_type           head;

   // Saturated position of the current byte
   generate
      if (POS_BITS > POS_W) begin : g_sat
         assign cur = (|byte_index_ff[POS_BITS-1:POS_W]) ? '1 : byte_index_ff[POS_W-1:0];
      end else begin : g_ext
         assign cur = POS_W'(byte_index_ff);
      end
   endgenerate

   // Handshakes
   assign rsp_valid = (rd_ff != cnt_ff);
   assign req_ready = (rd_ff == cnt_ff) || ((rd_ff + 2'd1 == cnt_ff) && rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Decode one byte into next state and its events
   always_comb begin
      logic       intr;
      logic       ok;
      logic [1:0] n;
      kind_type   k;
      logic [CP_W-1:0] acc;

      phase_in      = phase_ff;
      accum_in      = accum_ff;
      seq_begin_in  = seq_begin_ff;
      seq_len_in    = seq_len_ff;
      byte_index_in = byte_index_ff;
      all_valid_in  = all_valid_ff;
      for (int i = 0; i < 3; i++) begin
         ev_in[i] = '0;
      end
      n   = 2'd0;
      ok  = all_valid_ff;
      k   = KIND_VALID;
      acc = {accum_ff[CP_W-7:0], req_byte_value[5:0]};

      // Interrupted tail: report and restart at this byte
      intr = (phase_ff != TAIL_NONE) && (req_byte_value[7:6] != 2'b10);
      if (intr) begin
         ok = 1'b0;
         ev_in[n] = '{KIND_BAD_CONT, CP_W'(req_byte_value), cur, LEN_1B, 1'b0};
         n = n + 2'd1;
         phase_in = TAIL_NONE;
      end

      if (phase_ff == TAIL_NONE || intr) begin
         // Lead byte
         if (req_byte_value < 8'h80) begin
            ev_in[n] = '{KIND_VALID, CP_W'(req_byte_value), cur, LEN_1B, ok};
            n = n + 2'd1;
         end else if (req_byte_value < 8'hC0) begin
            ok = 1'b0;
            ev_in[n] = '{KIND_LONE_CONT, CP_W'(req_byte_value), cur, LEN_1B, 1'b0};
            n = n + 2'd1;
         end else if (req_byte_value < 8'hF8) begin
            if (req_byte_value < 8'hE0) begin
               accum_in   = CP_W'(req_byte_value[4:0]);
               phase_in   = TAIL_ONE;
               seq_len_in = LEN_2B;
            end else if (req_byte_value < 8'hF0) begin
               accum_in   = CP_W'(req_byte_value[3:0]);
               phase_in   = TAIL_TWO;
               seq_len_in = LEN_3B;
            end else begin
               accum_in   = CP_W'(req_byte_value[2:0]);
               phase_in   = TAIL_THREE;
               seq_len_in = LEN_4B;
            end
            seq_begin_in = cur;
         end else begin
            ok = 1'b0;
            ev_in[n] = '{KIND_BAD_START, CP_W'(req_byte_value), cur, LEN_1B, 1'b0};
            n = n + 2'd1;
         end
      end else begin
         // Continuation byte
         accum_in = acc;
         phase_in = phase_ff - 2'd1;
         if (phase_ff == TAIL_ONE) begin
            k = classify(acc, seq_len_ff);
            if (k != KIND_VALID) begin
               ok = 1'b0;
            end
            ev_in[n] = '{k, acc, seq_begin_ff, seq_len_ff, ok};
            n = n + 2'd1;
         end
      end

      if (req_end_of_stream) begin
         if (phase_in != TAIL_NONE) begin
            ok = 1'b0;
            ev_in[n] = '{KIND_TRUNC, '0, seq_begin_in, seq_len_in, 1'b0};
            n = n + 2'd1;
         end
         ev_in[n] = '{KIND_END, '0, cur, LEN_NONE, ok};
         n = n + 2'd1;
         phase_in      = TAIL_NONE;
         accum_in      = '0;
         seq_begin_in  = '0;
         seq_len_in    = LEN_NONE;
         byte_index_in = '0;
         all_valid_in  = 1'b1;
      end else begin
         all_valid_in = ok;
         if (byte_index_ff != '1) begin
            byte_index_in = byte_index_ff + POS_BITS'(1);
         end
      end

      cnt_in = n;
   end

   // Buffer read pointer
   always_comb begin
      rd_in = rd_ff;
      if (rsp_fire) begin
         rd_in = rd_ff + 2'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= TAIL_NONE;
         accum_ff      <= '0;
         seq_begin_ff  <= '0;
         seq_len_ff    <= LEN_NONE;
         byte_index_ff <= '0;
         all_valid_ff  <= 1'b1;
         cnt_ff        <= 2'd0;
         rd_ff         <= 2'd0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         seq_begin_ff  <= seq_begin_in;
         seq_len_ff    <= seq_len_in;
         byte_index_ff <= byte_index_in;
         all_valid_ff  <= all_valid_in;
         cnt_ff        <= cnt_in;
         rd_ff         <= 2'd0;
      end else begin
         rd_ff <= rd_in;
      end
   end

   // Event payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 3; i++) begin
            ev_ff[i] <= ev_in[i];
         end
      end
   end

   // Result outputs
   assign head             = ev_ff[rd_ff];
   assign rsp_event_kind   = head.kind;
   assign rsp_code_point   = head.cp;
   assign rsp_seq_position = head.pos;
   assign rsp_seq_bytes    = head.len;
   assign rsp_stream_ok    = head.ok;
   assign rsp_run_last     = (rd_ff + 2'd1 == cnt_ff);

   // Checks
   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ff <= cnt_ff)
      else $error("read pointer passed event count");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_END |-> rsp_run_last)
      else $error("end event not last of its byte");

   a_err_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == KIND_LONE_CONT || rsp_event_kind == KIND_BAD_START
         || rsp_event_kind == KIND_BAD_CONT || rsp_event_kind == KIND_TRUNC)
      |-> !rsp_stream_ok)
      else $error("error event with stream_ok set");

   a_eos_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_end_of_stream |=> phase_ff == TAIL_NONE && byte_index_ff == '0
         && all_valid_ff)
      else $error("decoder not cleared after final byte");

endmodule
